// File: src/nps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the note priority stack.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int STACK_SLOTS = 8;
  localparam int IDX_W       = $clog2(STACK_SLOTS);
  localparam int CNT_W       = $clog2(STACK_SLOTS + 1);

  localparam int CMD_W  = 3;
  localparam int NOTE_W = 7;
  localparam int POS_W  = 3;
  localparam int CFG_W  = 4;
  localparam int OUT_W  = 8;
  localparam int FPOS_W = 4;
  localparam int DEPTH_W = 4;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DROP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEEK = 3'd4;

  localparam logic [CFG_W-1:0]         MAX_DEPTH_RST = 4'd4;
  localparam logic signed [OUT_W-1:0]  NULL_NOTE     = 8'shFF;
  localparam logic signed [FPOS_W-1:0] NULL_FPOS     = 4'shF;

  typedef struct packed {
    logic [NOTE_W-1:0] val;
    logic [NOTE_W-1:0] vel;
  } note_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NOTE_W-1:0] note_value;
    logic [NOTE_W-1:0] note_velocity;
    logic [POS_W-1:0]  position;
  } cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]  value_out;
    logic signed [OUT_W-1:0]  velocity_out;
    logic signed [FPOS_W-1:0] found_position;
    logic [DEPTH_W-1:0]       depth_now;
    logic                     took_effect;
  } res_t;

endpackage
`default_nettype wire

// File: src/nps_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nps_in_if
// Command channel: valid/ready handshake with one command per beat.
// ----------------------------------------------------------------------------
interface nps_in_if import nps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NOTE_W-1:0] note_value;
  logic [NOTE_W-1:0] note_velocity;
  logic [POS_W-1:0]  position;

  modport source (output valid, command, note_value, note_velocity, position,
                  input ready);
  modport sink   (input valid, command, note_value, note_velocity, position,
                  output ready);
endinterface
`default_nettype wire

// File: src/nps_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nps_out_if
// Result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface nps_out_if import nps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  value_out;
  logic signed [OUT_W-1:0]  velocity_out;
  logic signed [FPOS_W-1:0] found_position;
  logic [DEPTH_W-1:0]       depth_now;
  logic                     took_effect;

  modport source (output valid, value_out, velocity_out, found_position, depth_now,
                  took_effect, input ready);
  modport sink   (input valid, value_out, velocity_out, found_position, depth_now,
                  took_effect, output ready);
endinterface
`default_nettype wire

// File: src/nps_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nps_in_stage
// Command register: captures one beat and holds it until the core executes it.
// ----------------------------------------------------------------------------
module nps_in_stage import nps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  nps_in_if.sink    in_ch,
  input  wire logic adv,
  output logic      vld,
  output cmd_t      cmd
);

  logic vld_r;
  cmd_t cmd_r;
  logic take;

  assign in_ch.ready = !vld_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (adv) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= '{command:       in_ch.command,
                 note_value:    in_ch.note_value,
                 note_velocity: in_ch.note_velocity,
                 position:      in_ch.position};
    end
  end

  assign vld = vld_r;
  assign cmd = cmd_r;

endmodule
`default_nettype wire

// File: src/nps_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nps_core
// Stack cells, held count, depth limit; one command per cycle on exec.
// ----------------------------------------------------------------------------
module nps_core import nps_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             exec,
  input  cmd_t                  cmd,
  output res_t                  res
);

  // cell 0 is the top of the stack
  note_t              store_r   [STACK_SLOTS];
  note_t              store_nxt [STACK_SLOTS];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [CFG_W-1:0]   max_depth_r;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   pos_ext;
  note_t              peek_note;

  assign limit     = (int'(max_depth_r) > STACK_SLOTS) ? CNT_W'(STACK_SLOTS)
                                                       : CNT_W'(max_depth_r);
  assign pos_ext   = CNT_W'(cmd.position);
  assign peek_note = store_r[cmd.position[IDX_W-1:0]];

  always_comb begin
    store_nxt          = store_r;
    count_nxt          = count_r;
    res.value_out      = NULL_NOTE;
    res.velocity_out   = NULL_NOTE;
    res.found_position = NULL_FPOS;
    res.took_effect    = 1'b0;
    case (cmd.command)
      CMD_PUSH: begin
        if (count_r < limit) begin
          store_nxt[0] = '{val: cmd.note_value, vel: cmd.note_velocity};
          for (int i = 1; i < STACK_SLOTS; i++) begin
            store_nxt[i] = store_r[i-1];
          end
          count_nxt       = count_r + 1'b1;
          res.took_effect = 1'b1;
        end
      end
      CMD_POP: begin
        if (count_r != '0) begin
          for (int i = 0; i < STACK_SLOTS - 1; i++) begin
            store_nxt[i] = store_r[i+1];
          end
          count_nxt       = count_r - 1'b1;
          res.took_effect = 1'b1;
          if (count_r > CNT_W'(1)) begin
            res.value_out    = {1'b0, store_r[1].val};
            res.velocity_out = {1'b0, store_r[1].vel};
          end
        end
      end
      CMD_PEEK: begin
        if (pos_ext < count_r) begin
          res.value_out    = {1'b0, peek_note.val};
          res.velocity_out = {1'b0, peek_note.vel};
        end
      end
      CMD_DROP: begin
        if (pos_ext < count_r) begin
          // cells below the dropped one move up by one
          for (int i = 0; i < STACK_SLOTS - 1; i++) begin
            if (CNT_W'(i) >= pos_ext) begin
              store_nxt[i] = store_r[i+1];
            end
          end
          count_nxt       = count_r - 1'b1;
          res.took_effect = 1'b1;
        end
      end
      CMD_SEEK: begin
        // deepest match wins: later cells override earlier ones
        for (int i = 0; i < STACK_SLOTS; i++) begin
          if (CNT_W'(i) < count_r && store_r[i].val == cmd.note_value) begin
            res.found_position = FPOS_W'(i);
          end
        end
      end
      default: ;
    endcase
    res.depth_now = DEPTH_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      max_depth_r <= MAX_DEPTH_RST;
    end else begin
      if (exec) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        max_depth_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      store_r <= store_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/nps_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nps_out_stage
// Result register: holds a finished result until the sink takes the beat.
// ----------------------------------------------------------------------------
module nps_out_stage import nps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  res_t      res,
  output logic      adv,
  nps_out_if.source out_ch
);

  logic vld_r;
  res_t res_r;

  assign adv = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.value_out      = res_r.value_out;
  assign out_ch.velocity_out   = res_r.velocity_out;
  assign out_ch.found_position = res_r.found_position;
  assign out_ch.depth_now      = res_r.depth_now;
  assign out_ch.took_effect    = res_r.took_effect;

endmodule
`default_nettype wire

// File: src/note_priority_stack.sv
// The command register feeds the stack update, whose result is registered.
// Throughput: one command per cycle unless the output stalls; the stack
//   update is combinational shifting and parallel compares between registers.
// Reset: synchronous, active low; the stack is emptied and max_depth goes to 4.
//   Stack cells are not cleared; only held entries are ever read.
`default_nettype none
// ----------------------------------------------------------------------------
// note_priority_stack
// Bounded last-note priority stack with push, pop, peek, drop and seek.
// ----------------------------------------------------------------------------
module note_priority_stack import nps_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  nps_in_if.sink                in_ch,
  nps_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic adv;
  logic cmd_vld;
  logic exec;
  cmd_t cmd;
  res_t res;

  assign exec = cmd_vld && adv;

  nps_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .vld   (cmd_vld),
    .cmd   (cmd)
  );

  nps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .exec      (exec),
    .cmd       (cmd),
    .res       (res)
  );

  nps_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (exec),
    .res    (res),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// File: src/nps_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks on the result channel of the note priority stack.
// ----------------------------------------------------------------------------
module nps_checker import nps_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [OUT_W-1:0]  value_out,
  input wire logic signed [OUT_W-1:0]  velocity_out,
  input wire logic signed [FPOS_W-1:0] found_position,
  input wire logic [DEPTH_W-1:0]       depth_now,
  input wire logic                     took_effect
);

  // a stalled result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(value_out)
      && $stable(velocity_out) && $stable(found_position)
      && $stable(depth_now) && $stable(took_effect))
    else $error("result beat changed while stalled");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> depth_now <= DEPTH_W'(STACK_SLOTS))
    else $error("depth beyond stack size");

  // a returned note is whole: value and velocity are null together
  a_null_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (value_out == NULL_NOTE) == (velocity_out == NULL_NOTE))
    else $error("half a null note");

  // a seek hit names a held position and never comes with a note
  a_seek: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found_position != NULL_FPOS |->
      !found_position[FPOS_W-1] && DEPTH_W'(found_position) < depth_now
      && value_out == NULL_NOTE && !took_effect)
    else $error("seek position out of range");

endmodule

bind note_priority_stack nps_checker u_nps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .value_out      (out_ch.value_out),
  .velocity_out   (out_ch.velocity_out),
  .found_position (out_ch.found_position),
  .depth_now      (out_ch.depth_now),
  .took_effect    (out_ch.took_effect)
);
`default_nettype wire
